@@ hw/rtl/b64e_pkg.sv @@
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types, constants and the sextet-to-ASCII map of the base64 encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

    localparam int unsigned CHAR_W      = 7;
    localparam int unsigned JOB_CHARS   = 4;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [CHAR_W-1:0] CHAR_PAD = 7'h3d;
    localparam logic [CHAR_W-1:0] CHAR_PLUS = 7'h2b;
    localparam logic [CHAR_W-1:0] CHAR_SLASH = 7'h2f;

    typedef enum logic [2:0] {
        PH0 = 3'b001,
        PH1 = 3'b010,
        PH2 = 3'b100
    } t_phase;

    typedef struct packed {
        logic [JOB_CHARS-1:0][CHAR_W-1:0] chars;
        logic [1:0]                       last_idx;
        logic                             last;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic [CHAR_W-1:0] sextet_char(input logic [5:0] s);
        logic [CHAR_W-1:0] sx;
        sx = {1'b0, s};
        if (s < 6'd26) begin
            return 7'h41 + sx;
        end else if (s < 6'd52) begin
            return 7'h61 + sx - 7'd26;
        end else if (s < 6'd62) begin
            return 7'h30 + sx - 7'd52;
        end else if (s == 6'd62) begin
            return CHAR_PLUS;
        end else begin
            return CHAR_SLASH;
        end
    endfunction

endpackage

@@ hw/rtl/b64e_front.sv @@
// ----------------------------------------------------------------------------
// b64e_front
// Accepts message bytes, tracks group phase and carry bits, and builds one
// character job per byte for the queue.
// ----------------------------------------------------------------------------
module b64e_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [7:0]          i_data_byte,
    input  logic                i_last_byte,
    input  b64e_pkg::t_q_stat   i_q_stat,
    output logic                o_push,
    output b64e_pkg::t_job      o_job
);

    b64e_pkg::t_phase r_phase, n_phase;
    logic [3:0]       r_carry, n_carry;

    assign o_push = i_valid && !i_q_stat.full;

    always_comb begin
        o_job          = '0;
        o_job.last     = i_last_byte;
        n_phase        = r_phase;
        n_carry        = r_carry;
        unique case (r_phase)
            b64e_pkg::PH1: begin
                o_job.chars[0] = b64e_pkg::sextet_char({r_carry[1:0], i_data_byte[7:4]});
                o_job.chars[1] = b64e_pkg::sextet_char({i_data_byte[3:0], 2'b00});
                o_job.chars[2] = b64e_pkg::CHAR_PAD;
                o_job.last_idx = i_last_byte ? 2'd2 : 2'd0;
                n_phase        = b64e_pkg::PH2;
                n_carry        = i_data_byte[3:0];
            end
            b64e_pkg::PH2: begin
                o_job.chars[0] = b64e_pkg::sextet_char({r_carry, i_data_byte[7:6]});
                o_job.chars[1] = b64e_pkg::sextet_char(i_data_byte[5:0]);
                o_job.last_idx = 2'd1;
                n_phase        = b64e_pkg::PH0;
                n_carry        = '0;
            end
            default: begin
                o_job.chars[0] = b64e_pkg::sextet_char(i_data_byte[7:2]);
                o_job.chars[1] = b64e_pkg::sextet_char({i_data_byte[1:0], 4'b0000});
                o_job.chars[2] = b64e_pkg::CHAR_PAD;
                o_job.chars[3] = b64e_pkg::CHAR_PAD;
                o_job.last_idx = i_last_byte ? 2'd3 : 2'd0;
                n_phase        = b64e_pkg::PH1;
                n_carry        = {2'b00, i_data_byte[1:0]};
            end
        endcase
        if (i_last_byte) begin
            n_phase = b64e_pkg::PH0;
            n_carry = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= b64e_pkg::PH0;
            r_carry <= '0;
        end else if (o_push) begin
            r_phase <= n_phase;
            r_carry <= n_carry;
        end
    end

    a_last_resets_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && i_last_byte |=> r_phase == b64e_pkg::PH0 && r_carry == 4'd0)
        else $error("group state not cleared after last byte");

endmodule

@@ hw/rtl/b64e_queue.sv @@
// ----------------------------------------------------------------------------
// b64e_queue
// Short job queue between the byte front end and the character back end.
// ----------------------------------------------------------------------------
module b64e_queue #(
    parameter int unsigned DEPTH = b64e_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  b64e_pkg::t_job      i_job,
    input  logic                i_pop,
    output b64e_pkg::t_job      o_job,
    output b64e_pkg::t_q_stat   o_stat
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    b64e_pkg::t_job   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_job        = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_next(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_next(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stat.full |-> !i_push)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stat.empty |-> !i_pop)
        else $error("pop from empty queue");

endmodule

@@ hw/rtl/b64e_back.sv @@
// ----------------------------------------------------------------------------
// b64e_back
// Walks the characters of the head job, one per cycle while the output is
// not stalled, into the output register.
// ----------------------------------------------------------------------------
module b64e_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  b64e_pkg::t_job              i_job,
    input  b64e_pkg::t_q_stat           i_q_stat,
    output logic                        o_pop,
    input  logic                        i_stall,
    output logic                        o_valid,
    output logic [b64e_pkg::CHAR_W-1:0] o_out_char,
    output logic                        o_last_char
);

    logic                        r_valid;
    logic [b64e_pkg::CHAR_W-1:0] r_char;
    logic                        r_last;
    logic [1:0]                  r_idx;
    logic                        emit, at_end;

    assign emit   = !i_q_stat.empty && (!r_valid || !i_stall);
    assign at_end = (r_idx == i_job.last_idx);
    assign o_pop  = emit && at_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (emit) begin
                r_valid <= 1'b1;
                r_idx   <= at_end ? 2'd0 : r_idx + 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_char <= i_job.chars[r_idx];
            r_last <= i_job.last && at_end;
        end
    end

    assign o_valid     = r_valid;
    assign o_out_char  = r_char;
    assign o_last_char = r_last;

    a_idx_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_stat.empty |-> r_idx == 2'd0)
        else $error("character index not at start with empty queue");

    a_idx_in_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_q_stat.empty |-> r_idx <= i_job.last_idx)
        else $error("character index beyond head job");

endmodule

@@ hw/rtl/base64_stream_encoder.sv @@
// ----------------------------------------------------------------------------
// base64_stream_encoder
// Standard base64 encoder: one message byte in per item, one ASCII
// character out per item.
// ----------------------------------------------------------------------------
// Each accepted byte becomes a job of one to four characters (two at the
// end of a three-byte group, up to four with flush and '=' padding on the
// last byte); a job queue of QUEUE_DEPTH entries sits between the byte input
// and the character output. The output register delivers one character per
// cycle while jobs are queued and i_stall is low; input bytes are taken in
// back to back cycles while the queue has room. o_last_char marks the final
// character of each message.
module base64_stream_encoder #(
    parameter int unsigned QUEUE_DEPTH = b64e_pkg::QUEUE_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [7:0]                  i_data_byte,
    input  logic                        i_last_byte,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [b64e_pkg::CHAR_W-1:0] o_out_char,
    output logic                        o_last_char
);

    b64e_pkg::t_job    push_job, head_job;
    b64e_pkg::t_q_stat q_stat;
    logic              push, pop;

    assign o_stall = q_stat.full;

    b64e_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_q_stat    (q_stat),
        .o_push      (push),
        .o_job       (push_job)
    );

    b64e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_stat  (q_stat)
    );

    b64e_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (head_job),
        .i_q_stat    (q_stat),
        .o_pop       (pop),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_out_char  (o_out_char),
        .o_last_char (o_last_char)
    );

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the base64 stream encoder.
// ----------------------------------------------------------------------------
// A short table of directed bytes runs first: all-zero and all-one bytes,
// a final byte at each of the three group positions, and the '+' and '/'
// characters. Some rows carry their expected text typed in. After that come
// random messages of random length in four traffic phases: no idling, sparse
// input, heavy output stall, and light idling on both sides. A software
// encoder tracks the group position and the leftover bits and queues the
// characters that each accepted byte must produce. Every character that
// leaves the block is checked against the oldest queued one.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int PHASE_BYTES    = 85;
    localparam int N_DIRECTED     = 21;

    typedef struct packed {
        logic [b64e_pkg::CHAR_W-1:0] ch;
        logic                        last;
    } t_char_exp;

    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic [2:0]  n_typed;
        logic [31:0] typed_text;
    } t_stim_row;

    localparam t_stim_row DIRECTED_ROWS [N_DIRECTED] = '{
        '{8'h00, 1'b1, 3'd4, "AA=="},
        '{8'hff, 1'b1, 3'd4, "/w=="},
        '{8'hff, 1'b0, 3'd1, "/"},
        '{8'hff, 1'b1, 3'd3, "/8="},
        '{8'h00, 1'b0, 3'd1, "A"},
        '{8'h00, 1'b0, 3'd1, "A"},
        '{8'h00, 1'b1, 3'd2, "AA"},
        '{8'hfb, 1'b0, 3'd1, "+"},
        '{8'hef, 1'b0, 3'd0, 32'd0},
        '{8'hbe, 1'b0, 3'd0, 32'd0},
        '{8'h4d, 1'b0, 3'd0, 32'd0},
        '{8'h61, 1'b0, 3'd0, 32'd0},
        '{8'h6e, 1'b1, 3'd0, 32'd0},
        '{8'h80, 1'b0, 3'd0, 32'd0},
        '{8'h01, 1'b1, 3'd0, 32'd0},
        '{8'h7f, 1'b0, 3'd0, 32'd0},
        '{8'haa, 1'b0, 3'd0, 32'd0},
        '{8'h55, 1'b1, 3'd0, 32'd0},
        '{8'h3c, 1'b1, 3'd0, 32'd0},
        '{8'hc3, 1'b0, 3'd0, 32'd0},
        '{8'h5a, 1'b1, 3'd0, 32'd0}
    };

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        i_valid;
    logic                        o_stall;
    logic [7:0]                  i_data_byte;
    logic                        i_last_byte;
    logic                        o_valid;
    logic                        i_stall = 1'b0;
    logic [b64e_pkg::CHAR_W-1:0] o_out_char;
    logic                        o_last_char;

    t_char_exp         expected_chars [$];
    b64e_pkg::t_phase  enc_phase = b64e_pkg::PH0;
    logic [3:0]        enc_carry = 4'd0;
    int                src_idle_pct = 0;
    int                sink_stall_pct = 0;
    int                quiet_cycles = 0;
    int                fail_count = 0;

    base64_stream_encoder i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_char  (o_out_char),
        .o_last_char (o_last_char)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic [b64e_pkg::CHAR_W-1:0] ascii_of(input logic [5:0] s);
        logic [b64e_pkg::CHAR_W-1:0] v;
        v = {1'b0, s};
        if (s <= 6'd25) begin
            return 7'd65 + v;
        end else if (s <= 6'd51) begin
            return 7'd71 + v;
        end else if (s <= 6'd61) begin
            return v - 7'd4;
        end else if (s == 6'd62) begin
            return b64e_pkg::CHAR_PLUS;
        end
        return b64e_pkg::CHAR_SLASH;
    endfunction

    task automatic queue_char(input logic [b64e_pkg::CHAR_W-1:0] ch, input logic l);
        t_char_exp e;
        e.ch   = ch;
        e.last = l;
        expected_chars.insert(expected_chars.size(), e);
    endtask

    task automatic predict_chars(input logic [7:0] b, input logic l);
        case (enc_phase)
            b64e_pkg::PH1: begin
                queue_char(ascii_of({enc_carry[1:0], b[7:4]}), 1'b0);
                enc_carry = b[3:0];
                enc_phase = b64e_pkg::PH2;
                if (l) begin
                    queue_char(ascii_of({enc_carry, 2'b00}), 1'b0);
                    queue_char(b64e_pkg::CHAR_PAD, 1'b1);
                end
            end
            b64e_pkg::PH2: begin
                queue_char(ascii_of({enc_carry, b[7:6]}), 1'b0);
                queue_char(ascii_of(b[5:0]), l);
                enc_carry = 4'd0;
                enc_phase = b64e_pkg::PH0;
            end
            default: begin
                queue_char(ascii_of(b[7:2]), 1'b0);
                enc_carry = {2'b00, b[1:0]};
                enc_phase = b64e_pkg::PH1;
                if (l) begin
                    queue_char(ascii_of({b[1:0], 4'b0000}), 1'b0);
                    queue_char(b64e_pkg::CHAR_PAD, 1'b0);
                    queue_char(b64e_pkg::CHAR_PAD, 1'b1);
                end
            end
        endcase
        if (l) begin
            enc_phase = b64e_pkg::PH0;
            enc_carry = 4'd0;
        end
    endtask

    // hold the item until it is taken; returns at the accepting edge
    task automatic send_byte(input logic [7:0] b, input logic l);
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= l;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < sink_stall_pct);
    end

    always @(posedge i_clk) begin
        t_char_exp want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_chars.size() == 0) begin
                $error("unexpected char: out_char %h last_char %b", o_out_char, o_last_char);
                fail_count++;
            end else begin
                want = expected_chars.pop_front();
                if (o_out_char !== want.ch) begin
                    $error("out_char: expected %h, got %h", want.ch, o_out_char);
                    fail_count++;
                end
                if (o_last_char !== want.last) begin
                    $error("last_char: expected %b, got %b", want.last, o_last_char);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int base;
        int msg_len;
        int phase_bytes;
        t_stim_row row;

        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_data_byte = 8'd0;
        i_last_byte = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < N_DIRECTED; r++) begin
            row = DIRECTED_ROWS[r];
            send_byte(row.data, row.last);
            base = expected_chars.size();
            predict_chars(row.data, row.last);
            if (row.n_typed != 3'd0) begin
                // replace the computed chars with the typed-in text
                while (expected_chars.size() > base) begin
                    expected_chars.delete(expected_chars.size() - 1);
                end
                for (int k = 0; k < row.n_typed; k++) begin
                    queue_char(row.typed_text[8*(row.n_typed-1-k) +: 7],
                               row.last && (k == row.n_typed - 1));
                end
            end
        end

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 85; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 85; end
                default: begin src_idle_pct = 14; sink_stall_pct = 14; end
            endcase
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES) begin
                msg_len = ($urandom_range(7) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(1, 8);
                for (int k = 0; k < msg_len; k++) begin
                    logic [7:0] b;
                    logic       l;
                    b = 8'($urandom_range(255));
                    l = (k == msg_len - 1);
                    send_byte(b, l);
                    predict_chars(b, l);
                    phase_bytes++;
                end
            end
        end
        i_valid <= 1'b0;

        while (expected_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ base64_stream_encoder.f @@
hw/rtl/b64e_pkg.sv
hw/rtl/b64e_front.sv
hw/rtl/b64e_queue.sv
hw/rtl/b64e_back.sv
hw/rtl/base64_stream_encoder.sv
tb/tb_top.sv
